// File: rtl/c8eu_pkg.sv
// Shared types, codes and constants for the CHIP-8 execute unit.
`default_nettype none
package c8eu_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_VREGS   = 16;
    localparam int STK_DW      = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int VMEM_N      = NUM_VREGS - 1;

    localparam logic [3:0]  FLAG_REG    = 4'hF;
    localparam logic [11:0] START_RESET = 12'd512;
    localparam logic [11:0] PC_STEP     = 12'd2;

    typedef enum logic [3:0] {
        OP_RET     = 4'd0,
        OP_JUMP    = 4'd1,
        OP_CALL    = 4'd2,
        OP_SEQ_IMM = 4'd3,
        OP_SNE_IMM = 4'd4,
        OP_SEQ_REG = 4'd5,
        OP_SNE_REG = 4'd6,
        OP_LOAD    = 4'd7,
        OP_ALU     = 4'd8,
        OP_ADDI    = 4'd9,
        OP_SETI    = 4'd10,
        OP_ADV     = 4'd11,
        OP_INVALID = 4'd12
    } op_t;

    typedef enum logic [3:0] {
        FN_MOV  = 4'h0,
        FN_OR   = 4'h1,
        FN_AND  = 4'h2,
        FN_XOR  = 4'h3,
        FN_ADD  = 4'h4,
        FN_SUB  = 4'h5,
        FN_SHR  = 4'h6,
        FN_SUBN = 4'h7,
        FN_SHL  = 4'hE
    } alu_fn_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    // V register write request: result to Vx, flag to VF
    typedef struct packed {
        logic       res_we;
        logic [7:0] res;
        logic       flag_we;
        logic [7:0] flag;
        logic       flag_last;
    } vwr_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [11:0] data;
    } stk_ctrl_t;

    typedef struct packed {
        logic        empty;
        logic        full;
        logic [11:0] tos;
    } stk_stat_t;

endpackage
`default_nettype wire

// File: rtl/chip8_execute_unit_core.sv
// Top level of the CHIP-8 execute unit: input register, execute stage, result register.
//
//  channel | dir | signals                        | payload
//  s_      | in  | s_tvalid s_tready s_tdata/user | decoded instruction request
//  m_      | out | m_tvalid m_tready m_tdata/user | machine state and status
//  cfg_    | in  | cfg_we cfg_wdata               | start address (loads pc)
//
// One instruction per cycle unless the result side stalls; m_tvalid rises on execution.
// The accepting edge registers the request and reads Vx/Vy from the register file (with
// forwarding from the instruction executing alongside); fire at a later edge executes it.
// A stalled result register holds the execute stage, and the input register then fills.
// Synchronous reset clears V registers (valid bits), index, stack depth, pc = 512.
`default_nettype none
module chip8_execute_unit_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] reg_x, [7:4] reg_y, [11:8] alu_function, [19:12] immediate,
    // [31:20] target_address
    input  wire logic [31:0] s_tdata,
    // [3:0] operation
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [11:0] pc_out, [23:12] index_out, [31:24] vx_out, [39:32] vf_out
    output logic      [39:0] m_tdata,
    // [1:0] status
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);

    logic                in_vld_reg;
    c8eu_pkg::op_t       op_reg;
    logic [3:0]          x_reg;
    logic [3:0]          fn_reg;
    logic [7:0]          imm_reg;
    logic [11:0]         addr_reg;
    logic                accept;
    logic                fire;

    logic [11:0]         pc_reg;
    logic [11:0]         pc_next;
    logic [11:0]         idx_reg;
    logic [11:0]         idx_next;
    logic [11:0]         pc_plus2;

    logic                out_vld_reg;
    logic [39:0]         out_data_reg;
    logic [1:0]          out_user_reg;

    logic [7:0]          vx;
    logic [7:0]          vy;
    logic [7:0]          vx_new;
    logic [7:0]          vf_new;
    c8eu_pkg::vwr_t      alu_wr;
    c8eu_pkg::vwr_t      vwr;
    c8eu_pkg::stk_ctrl_t stk_ctrl;
    c8eu_pkg::stk_stat_t stk_stat;
    c8eu_pkg::status_t   status;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (accept) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= c8eu_pkg::op_t'(s_tuser);
            x_reg    <= s_tdata[3:0];
            fn_reg   <= s_tdata[11:8];
            imm_reg  <= s_tdata[19:12];
            addr_reg <= s_tdata[31:20];
        end
    end

    c8eu_vfile u_vfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_x    (s_tdata[3:0]),
        .rd_y    (s_tdata[7:4]),
        .wr_en   (fire),
        .wr_x    (x_reg),
        .wr      (vwr),
        .vx      (vx),
        .vy      (vy),
        .vx_new  (vx_new),
        .vf_new  (vf_new)
    );

    c8eu_alu u_alu (
        .fn (fn_reg),
        .vx (vx),
        .vy (vy),
        .wr (alu_wr)
    );

    c8eu_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stk_ctrl),
        .stat    (stk_stat)
    );

    assign pc_plus2 = pc_reg + c8eu_pkg::PC_STEP;

    always_comb begin
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        status        = c8eu_pkg::ST_OK;
        vwr           = '0;
        stk_ctrl      = '0;
        stk_ctrl.data = pc_reg;
        case (op_reg)
            c8eu_pkg::OP_RET: begin
                if (stk_stat.empty) begin
                    status = c8eu_pkg::ST_UNDERFLOW;
                end else begin
                    stk_ctrl.pop = fire;
                    pc_next      = stk_stat.tos;
                end
            end
            c8eu_pkg::OP_JUMP: begin
                pc_next = addr_reg;
            end
            c8eu_pkg::OP_CALL: begin
                if (stk_stat.full) begin
                    status = c8eu_pkg::ST_OVERFLOW;
                end else begin
                    stk_ctrl.push = fire;
                    pc_next       = addr_reg;
                end
            end
            c8eu_pkg::OP_SEQ_IMM: begin
                if (vx == imm_reg) begin
                    pc_next = pc_plus2;
                end
            end
            c8eu_pkg::OP_SNE_IMM: begin
                if (vx != imm_reg) begin
                    pc_next = pc_plus2;
                end
            end
            c8eu_pkg::OP_SEQ_REG: begin
                if (vx == vy) begin
                    pc_next = pc_plus2;
                end
            end
            c8eu_pkg::OP_SNE_REG: begin
                if (vx != vy) begin
                    pc_next = pc_plus2;
                end
            end
            c8eu_pkg::OP_LOAD: begin
                vwr.res_we = 1'b1;
                vwr.res    = imm_reg;
            end
            c8eu_pkg::OP_ALU: begin
                vwr = alu_wr;
            end
            c8eu_pkg::OP_ADDI: begin
                vwr.res_we = 1'b1;
                vwr.res    = vx + imm_reg;
            end
            c8eu_pkg::OP_SETI: begin
                idx_next = addr_reg;
            end
            c8eu_pkg::OP_ADV: begin
                pc_next = pc_plus2;
            end
            default: begin
                status = c8eu_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= c8eu_pkg::START_RESET;
            idx_reg <= '0;
        end else if (cfg_we) begin
            pc_reg <= cfg_wdata;
        end else if (fire) begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {vf_new, vx_new, idx_next, pc_next};
            out_user_reg <= status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("executed request produced no result");

    a_error_keeps_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && status != c8eu_pkg::ST_OK && !cfg_we) |=> $stable(pc_reg))
        else $error("faulting instruction changed pc");

endmodule
`default_nettype wire

// File: rtl/c8eu_alu.sv
// 8XY ALU group: result and flag for one instruction.
`default_nettype none
module c8eu_alu (
    input  wire logic [3:0] fn,
    input  wire logic [7:0] vx,
    input  wire logic [7:0] vy,
    output c8eu_pkg::vwr_t  wr
);

    logic [8:0] sum;

    assign sum = {1'b0, vx} + {1'b0, vy};

    always_comb begin
        wr = '0;
        case (c8eu_pkg::alu_fn_t'(fn))
            c8eu_pkg::FN_MOV: begin
                wr.res_we = 1'b1;
                wr.res    = vy;
            end
            c8eu_pkg::FN_OR: begin
                wr.res_we = 1'b1;
                wr.res    = vx | vy;
            end
            c8eu_pkg::FN_AND: begin
                wr.res_we = 1'b1;
                wr.res    = vx & vy;
            end
            c8eu_pkg::FN_XOR: begin
                wr.res_we = 1'b1;
                wr.res    = vx ^ vy;
            end
            c8eu_pkg::FN_ADD: begin
                wr.res_we  = 1'b1;
                wr.res     = sum[7:0];
                wr.flag_we = 1'b1;
                wr.flag    = {7'd0, sum[8]};
            end
            c8eu_pkg::FN_SUB: begin
                wr.res_we  = 1'b1;
                wr.res     = vx - vy;
                wr.flag_we = 1'b1;
                wr.flag    = {7'd0, vx >= vy};
            end
            c8eu_pkg::FN_SUBN: begin
                wr.res_we  = 1'b1;
                wr.res     = vy - vx;
                wr.flag_we = 1'b1;
                wr.flag    = {7'd0, vy >= vx};
            end
            c8eu_pkg::FN_SHR: begin
                wr.res_we    = 1'b1;
                wr.res       = {1'b0, vy[7:1]};
                wr.flag_we   = 1'b1;
                wr.flag      = {7'd0, vy[0]};
                wr.flag_last = 1'b1;
            end
            c8eu_pkg::FN_SHL: begin
                wr.res_we    = 1'b1;
                wr.res       = {vy[6:0], 1'b0};
                wr.flag_we   = 1'b1;
                wr.flag      = {7'd0, vy[7]};
                wr.flag_last = 1'b1;
            end
            default: begin
                wr = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/c8eu_vfile.sv
// V register file: V0-VE in a memory with valid bits, VF in a flop, registered reads.
`default_nettype none
module c8eu_vfile (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [3:0]    rd_x,
    input  wire logic [3:0]    rd_y,
    input  wire logic          wr_en,
    input  wire logic [3:0]    wr_x,
    input  wire c8eu_pkg::vwr_t wr,
    output logic      [7:0]    vx,
    output logic      [7:0]    vy,
    output logic      [7:0]    vx_new,
    output logic      [7:0]    vf_new
);

    logic [7:0]                  mem [c8eu_pkg::VMEM_N];
    logic [c8eu_pkg::VMEM_N-1:0] vld_reg;
    logic [c8eu_pkg::VMEM_N-1:0] vld_next;
    logic [7:0]                  rdx_reg;
    logic [7:0]                  rdy_reg;
    logic                        rdx15_reg;
    logic                        rdy15_reg;
    logic [7:0]                  vf_reg;
    logic [7:0]                  vf_next;
    logic                        mem_we;

    assign mem_we = wr_en && wr.res_we && !rdx15_reg;

    always_comb begin
        vld_next = vld_reg;
        if (mem_we) begin
            vld_next[wr_x] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vf_reg  <= '0;
        end else begin
            vld_reg <= vld_next;
            vf_reg  <= vf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_x] <= wr.res;
        end
        if (rd_en) begin
            rdx15_reg <= (rd_x == c8eu_pkg::FLAG_REG);
            rdy15_reg <= (rd_y == c8eu_pkg::FLAG_REG);
            if (rd_x == c8eu_pkg::FLAG_REG) begin
                rdx_reg <= '0;
            end else if (mem_we && wr_x == rd_x) begin
                rdx_reg <= wr.res;
            end else if (vld_reg[rd_x]) begin
                rdx_reg <= mem[rd_x];
            end else begin
                rdx_reg <= '0;
            end
            if (rd_y == c8eu_pkg::FLAG_REG) begin
                rdy_reg <= '0;
            end else if (mem_we && wr_x == rd_y) begin
                rdy_reg <= wr.res;
            end else if (vld_reg[rd_y]) begin
                rdy_reg <= mem[rd_y];
            end else begin
                rdy_reg <= '0;
            end
        end
    end

    assign vx = rdx15_reg ? vf_reg : rdx_reg;
    assign vy = rdy15_reg ? vf_reg : rdy_reg;

    // Vx = VF: add/sub keep the result, shifts keep the flag
    always_comb begin
        if (rdx15_reg) begin
            if (wr.flag_we && (wr.flag_last || !wr.res_we)) begin
                vf_new = wr.flag;
            end else if (wr.res_we) begin
                vf_new = wr.res;
            end else begin
                vf_new = vf_reg;
            end
        end else begin
            vf_new = wr.flag_we ? wr.flag : vf_reg;
        end
        if (rdx15_reg) begin
            vx_new = vf_new;
        end else begin
            vx_new = wr.res_we ? wr.res : vx;
        end
        vf_next = wr_en ? vf_new : vf_reg;
    end

endmodule
`default_nettype wire

// File: rtl/c8eu_stack.sv
// Return stack: top entry in a flop, the rest in a memory with a prefetched next entry.
`default_nettype none
module c8eu_stack (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire c8eu_pkg::stk_ctrl_t ctrl,
    output c8eu_pkg::stk_stat_t stat
);

    logic [11:0]                 mem [c8eu_pkg::STACK_DEPTH];
    logic [c8eu_pkg::STK_DW-1:0] depth_reg;
    logic [c8eu_pkg::STK_DW-1:0] depth_next;
    logic [c8eu_pkg::STK_DW-1:0] depth_m1;
    logic [c8eu_pkg::STK_DW-1:0] depth_m3;
    logic [11:0]                 tos_reg;
    logic [11:0]                 under_reg;

    assign depth_m1 = depth_reg - c8eu_pkg::STK_DW'(1);
    assign depth_m3 = depth_reg - c8eu_pkg::STK_DW'(3);

    always_comb begin
        depth_next = depth_reg;
        if (ctrl.push) begin
            depth_next = depth_reg + c8eu_pkg::STK_DW'(1);
        end else if (ctrl.pop) begin
            depth_next = depth_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // under_reg tracks the entry just below the top
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            if (depth_reg != '0) begin
                mem[depth_m1[c8eu_pkg::STK_AW-1:0]] <= tos_reg;
            end
            tos_reg   <= ctrl.data;
            under_reg <= tos_reg;
        end else if (ctrl.pop) begin
            tos_reg   <= under_reg;
            under_reg <= mem[depth_m3[c8eu_pkg::STK_AW-1:0]];
        end
    end

    assign stat.empty = (depth_reg == '0);
    assign stat.full  = (depth_reg == c8eu_pkg::STK_DW'(c8eu_pkg::STACK_DEPTH));
    assign stat.tos   = tos_reg;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.push && stat.full))
        else $error("push on full stack");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.pop && stat.empty))
        else $error("pop on empty stack");

    a_push_tos: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> (tos_reg == $past(ctrl.data)))
        else $error("top of stack lost pushed address");

endmodule
`default_nettype wire

// File: sim/chip8_state_checker.sv
// Checker for the CHIP-8 execute unit: predicts machine state per request and compares results.
module chip8_state_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] index;
        logic [7:0]  vx;
        logic [7:0]  vf;
        logic [1:0]  status;
    } mach_state_t;

    logic [7:0]  vreg [c8eu_pkg::NUM_VREGS];
    logic [11:0] ret_stack [c8eu_pkg::STACK_DEPTH];
    logic [11:0] index_r;
    logic [11:0] pc_r;
    int          depth;
    mach_state_t state_q [$];
    int          errs = 0;
    int          n_checked = 0;

    task automatic run_alu(input logic [3:0] fn, input logic [3:0] x, input logic [3:0] y);
        logic [7:0] vx;
        logic [7:0] vy;
        logic [8:0] sum;
        vx = vreg[x];
        vy = vreg[y];
        case (fn)
            c8eu_pkg::FN_MOV: vreg[x] = vy;
            c8eu_pkg::FN_OR:  vreg[x] = vx | vy;
            c8eu_pkg::FN_AND: vreg[x] = vx & vy;
            c8eu_pkg::FN_XOR: vreg[x] = vx ^ vy;
            c8eu_pkg::FN_ADD: begin
                sum = {1'b0, vx} + {1'b0, vy};
                vreg[c8eu_pkg::FLAG_REG] = {7'd0, sum[8]};
                vreg[x] = sum[7:0];
            end
            c8eu_pkg::FN_SUB: begin
                vreg[c8eu_pkg::FLAG_REG] = (vx >= vy) ? 8'd1 : 8'd0;
                vreg[x] = vx - vy;
            end
            c8eu_pkg::FN_SHR: begin
                vreg[x] = vy >> 1;
                vreg[c8eu_pkg::FLAG_REG] = {7'd0, vy[0]};
            end
            c8eu_pkg::FN_SUBN: begin
                vreg[c8eu_pkg::FLAG_REG] = (vy >= vx) ? 8'd1 : 8'd0;
                vreg[x] = vy - vx;
            end
            c8eu_pkg::FN_SHL: begin
                vreg[x] = {vy[6:0], 1'b0};
                vreg[c8eu_pkg::FLAG_REG] = {7'd0, vy[7]};
            end
            default: ;
        endcase
    endtask

    task automatic exec_instr(input logic [3:0] op, input logic [31:0] data,
                              output mach_state_t res);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  imm;
        logic [11:0] addr;
        logic [1:0]  st;
        x    = data[3:0];
        y    = data[7:4];
        imm  = data[19:12];
        addr = data[31:20];
        st   = c8eu_pkg::ST_OK;
        case (op)
            c8eu_pkg::OP_RET: begin
                if (depth == 0) begin
                    st = c8eu_pkg::ST_UNDERFLOW;
                end else begin
                    depth--;
                    pc_r = ret_stack[depth];
                end
            end
            c8eu_pkg::OP_JUMP: pc_r = addr;
            c8eu_pkg::OP_CALL: begin
                if (depth >= c8eu_pkg::STACK_DEPTH) begin
                    st = c8eu_pkg::ST_OVERFLOW;
                end else begin
                    ret_stack[depth] = pc_r;
                    depth++;
                    pc_r = addr;
                end
            end
            c8eu_pkg::OP_SEQ_IMM: if (vreg[x] == imm) pc_r = pc_r + c8eu_pkg::PC_STEP;
            c8eu_pkg::OP_SNE_IMM: if (vreg[x] != imm) pc_r = pc_r + c8eu_pkg::PC_STEP;
            c8eu_pkg::OP_SEQ_REG: if (vreg[x] == vreg[y]) pc_r = pc_r + c8eu_pkg::PC_STEP;
            c8eu_pkg::OP_SNE_REG: if (vreg[x] != vreg[y]) pc_r = pc_r + c8eu_pkg::PC_STEP;
            c8eu_pkg::OP_LOAD:    vreg[x] = imm;
            c8eu_pkg::OP_ALU:     run_alu(data[11:8], x, y);
            c8eu_pkg::OP_ADDI:    vreg[x] = vreg[x] + imm;
            c8eu_pkg::OP_SETI:    index_r = addr;
            c8eu_pkg::OP_ADV:     pc_r = pc_r + c8eu_pkg::PC_STEP;
            default:              st = c8eu_pkg::ST_INVALID;
        endcase
        res = '{pc: pc_r, index: index_r, vx: vreg[x], vf: vreg[c8eu_pkg::FLAG_REG],
                status: st};
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (want !== got) begin
            errs++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        mach_state_t want;
        mach_state_t got;
        if (!aresetn) begin
            for (int i = 0; i < c8eu_pkg::NUM_VREGS; i++) vreg[i] = 8'd0;
            index_r = 12'd0;
            pc_r    = c8eu_pkg::START_RESET;
            depth   = 0;
            state_q.delete();
        end else begin
            if (cfg_we) pc_r = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = '{pc: m_tdata[11:0], index: m_tdata[23:12], vx: m_tdata[31:24],
                        vf: m_tdata[39:32], status: m_tuser};
                if (state_q.size() == 0) begin
                    errs++;
                    $display("%0t ns: result with nothing expected, actual %0h", $time, got);
                end else begin
                    want = state_q.pop_front();
                    compare_field("pc", want.pc, got.pc);
                    compare_field("index", want.index, got.index);
                    compare_field("vx", want.vx, got.vx);
                    compare_field("vf", want.vf, got.vf);
                    compare_field("status", want.status, got.status);
                    n_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                exec_instr(s_tuser, s_tdata, want);
                state_q = {state_q, want};
            end
        end
        fail_count <= errs;
        pending    <= state_q.size();
        checked    <= n_checked;
    end

endmodule

// File: sim/tb_chip8_execute_unit_core.sv
// Testbench top for the CHIP-8 execute unit: clock, reset, request stimulus and verdict.
module tb_chip8_execute_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire  [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          checked;

    int          sent = 0;
    int          settings = 0;
    int          bursts = 0;
    bit          send_steady = 1'b0;

    always #1 aclk = ~aclk;

    chip8_execute_unit_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    chip8_state_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    task automatic issue(input logic [3:0] op, input logic [3:0] x, input logic [3:0] y,
                         input logic [3:0] fn, input logic [7:0] imm,
                         input logic [11:0] addr);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {addr, imm, fn, y, x};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // drain all results, then load a new start address
    task automatic set_start(input logic [11:0] start);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    task automatic random_instr();
        logic [3:0] op;
        logic [7:0] imm;
        if ($urandom_range(0, 99) < 5) op = 4'($urandom_range(c8eu_pkg::OP_INVALID, 15));
        else op = 4'($urandom_range(c8eu_pkg::OP_RET, c8eu_pkg::OP_ADV));
        // narrow immediates so compares hit often
        case ($urandom_range(0, 3))
            0:       imm = 8'h00;
            1:       imm = 8'hFF;
            2:       imm = 8'($urandom_range(0, 3));
            default: imm = 8'($urandom);
        endcase
        issue(op, 4'($urandom), 4'($urandom), 4'($urandom), imm, 12'($urandom));
    endtask

    // nested calls that can pass the stack limit, then returns that can unwind past empty
    task automatic call_burst();
        int n;
        n = $urandom_range(12, c8eu_pkg::STACK_DEPTH + 2);
        bursts++;
        repeat (n) issue(c8eu_pkg::OP_CALL, 4'($urandom), 4'($urandom), c8eu_pkg::FN_MOV,
                         8'($urandom), 12'($urandom));
        repeat (n + $urandom_range(0, 2))
            issue(c8eu_pkg::OP_RET, 4'($urandom), 4'($urandom), c8eu_pkg::FN_MOV,
                  8'($urandom), 12'($urandom));
    endtask

    initial begin
        logic [11:0] starts [4];
        int target;
        starts = '{12'hFFF, 12'h000, 12'($urandom), c8eu_pkg::START_RESET};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        set_start(12'hFFE);
        issue(c8eu_pkg::OP_RET,     4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ADV,     4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_LOAD,    4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'hFF, 12'h000);
        issue(c8eu_pkg::OP_LOAD,    4'd1, 4'd0, c8eu_pkg::FN_MOV,  8'h01, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd0, 4'd1, c8eu_pkg::FN_ADD,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_LOAD,    4'd2, 4'd0, c8eu_pkg::FN_MOV,  8'h80, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd3, 4'd2, c8eu_pkg::FN_SHL,  8'h00, 12'h000);
        // shift into VF: flag written last wins
        issue(c8eu_pkg::OP_ALU,     4'hF, 4'd1, c8eu_pkg::FN_SHR,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_LOAD,    4'hF, 4'd0, c8eu_pkg::FN_MOV,  8'hFF, 12'h000);
        // add into VF: result written last wins
        issue(c8eu_pkg::OP_ALU,     4'hF, 4'd1, c8eu_pkg::FN_ADD,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd1, 4'd2, c8eu_pkg::FN_SUB,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd2, 4'd1, c8eu_pkg::FN_SUBN, 8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd4, 4'd2, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd4, 4'd0, c8eu_pkg::FN_OR,   8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd4, 4'd1, c8eu_pkg::FN_XOR,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ALU,     4'd4, 4'd1, 4'h8,              8'h00, 12'h000);
        issue(c8eu_pkg::OP_SEQ_IMM, 4'd3, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_SNE_IMM, 4'd3, 4'd0, c8eu_pkg::FN_MOV,  8'hFF, 12'h000);
        issue(c8eu_pkg::OP_SEQ_REG, 4'd0, 4'd3, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_SNE_REG, 4'd0, 4'd1, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_ADDI,    4'd1, 4'd0, c8eu_pkg::FN_MOV,  8'hFF, 12'h000);
        issue(c8eu_pkg::OP_SETI,    4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'hFFF);
        issue(c8eu_pkg::OP_JUMP,    4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'hFFF);
        issue(c8eu_pkg::OP_CALL,    4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_RET,     4'd0, 4'd0, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(c8eu_pkg::OP_INVALID, 4'd5, 4'd5, c8eu_pkg::FN_MOV,  8'h00, 12'h000);
        issue(4'hF,                 4'hF, 4'hF, 4'hF,              8'hFF, 12'hFFF);

        foreach (starts[i]) begin
            set_start(starts[i]);
            target = sent + 205;
            while (sent < target) begin
                if ($urandom_range(0, 59) == 0) call_burst();
                else random_instr();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("run covered %0d instructions under %0d start addresses, %0d stack bursts",
                 sent, settings, bursts);
        $display("%0d results compared field by field, %0d mismatching fields",
                 checked, fail_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: random stalls, one long hold to back up the input
    initial begin
        int  idle_left;
        int  taken;
        bit  steady;
        idle_left = 0;
        taken     = 0;
        steady    = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
                if ($urandom_range(0, 39) == 0) steady = !steady;
                idle_left = steady ? 0 : $urandom_range(0, 6);
                if (taken == 300) idle_left = 150;
            end else if (idle_left > 0) begin
                idle_left--;
            end
            m_tready <= (idle_left == 0);
        end
    end

    initial begin
        #400_000;
        $display("timeout with %0d requests sent", sent);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
